@@ rtl/mbg_pkg.sv @@
// Shared codes and widths for the maze carver.
package mbg_pkg;

  localparam int unsigned COORD_W = 8;
  localparam int unsigned MUL_W   = 8;
  localparam int unsigned C_W     = 17;
  localparam int unsigned ACC_W   = 18;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STEP   = 2'd1;
  localparam logic [1:0] OP_TARGET = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [2:0] ST_STARTED     = 3'd0;
  localparam logic [2:0] ST_CARVED      = 3'd1;
  localparam logic [2:0] ST_RETRY       = 3'd2;
  localparam logic [2:0] ST_BACKTRACKED = 3'd3;
  localparam logic [2:0] ST_FINISHED    = 3'd4;
  localparam logic [2:0] ST_PLACED      = 3'd5;
  localparam logic [2:0] ST_REJECTED    = 3'd6;
  localparam logic [2:0] ST_CELL_READ   = 3'd7;

  localparam logic [1:0] KIND_WALL   = 2'd0;
  localparam logic [1:0] KIND_FLOOR  = 2'd1;
  localparam logic [1:0] KIND_START  = 2'd2;
  localparam logic [1:0] KIND_TARGET = 2'd3;

  localparam logic [1:0] DIR_SOUTH = 2'd0;
  localparam logic [1:0] DIR_WEST  = 2'd1;
  localparam logic [1:0] DIR_NORTH = 2'd2;
  localparam logic [1:0] DIR_EAST  = 2'd3;

endpackage

@@ rtl/mbg_muladd.sv @@
// Shared multiply-add unit: cell addresses and squared distances.
module mbg_muladd (
  input  logic [mbg_pkg::MUL_W-1:0] a_i,
  input  logic [mbg_pkg::MUL_W-1:0] b_i,
  input  logic [mbg_pkg::C_W-1:0]   c_i,
  output logic [mbg_pkg::ACC_W-1:0] res_o
);
  import mbg_pkg::*;

  logic [2*MUL_W-1:0] prod;

  assign prod  = a_i * b_i;
  assign res_o = ACC_W'(prod) + ACC_W'(c_i);

endmodule

@@ rtl/mbg_ram.sv @@
// Single-port RAM with registered read data.
module mbg_ram #(
  parameter int unsigned DEPTH = 961,
  parameter int unsigned WIDTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/maze_backtracker_generator_top.sv @@
// Top level of the maze carver: sequencer, grid and path stack memories.
//
//  Channel   Handshake            Ports
//  command   start && !busy       op_i, pos_x_i, pos_y_i, pick_i
//  result    done_o, one cycle    status_o, cell_x_o, cell_y_o, wall_x_o, wall_y_o,
//                                 cell_kind_o
//
// After reset the grid is swept clear, one cell a cycle.
// From the accepting edge busy stays high on a start item (the sweep, then the start cell), on a
// target item and on a read item, and on a step item while the four candidate cells are read one
// a cycle through the single grid port before a retry, finish, backtrack or carve. A step outside
// carving and an early target rejection do not raise busy. Each result shows in the cycle in which
// busy falls, and cannot stall.
module maze_backtracker_generator_top #(
  parameter int unsigned MAZE_WIDTH  = 31,
  parameter int unsigned MAZE_HEIGHT = 31,
  parameter int unsigned STACK_DEPTH = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] op_i,
  input  logic [7:0] pos_x_i,
  input  logic [7:0] pos_y_i,
  input  logic [1:0] pick_i,
  output logic       done_o,
  output logic [2:0] status_o,
  output logic [7:0] cell_x_o,
  output logic [7:0] cell_y_o,
  output logic [7:0] wall_x_o,
  output logic [7:0] wall_y_o,
  output logic [1:0] cell_kind_o
);
  import mbg_pkg::*;

  localparam int unsigned CELLS = MAZE_WIDTH * MAZE_HEIGHT;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned SW    = $clog2(STACK_DEPTH);
  localparam int unsigned CW    = $clog2(STACK_DEPTH + 1);
  localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);
  localparam logic [8:0] X_HI  = 9'(MAZE_WIDTH - 2);
  localparam logic [8:0] Y_HI  = 9'(MAZE_HEIGHT - 2);
  localparam logic [8:0] X_LIM = 9'(MAZE_WIDTH);
  localparam logic [8:0] Y_LIM = 9'(MAZE_HEIGHT);
  localparam logic [MUL_W-1:0] W_MUL = MUL_W'(MAZE_WIDTH);
  localparam logic [ACC_W+1:0] SUM_WH = (ACC_W + 2)'(MAZE_WIDTH + MAZE_HEIGHT);
  localparam logic [CW-1:0] STK_FULL = CW'(STACK_DEPTH);

  typedef enum logic [13:0] {
    S_CLEAR  = 14'h0001,
    S_IDLE   = 14'h0002,
    S_INIT   = 14'h0004,
    S_READ   = 14'h0008,
    S_WAIT   = 14'h0010,
    S_DECIDE = 14'h0020,
    S_CARVE  = 14'h0040,
    S_POPW   = 14'h0080,
    S_TRD    = 14'h0100,
    S_TWAIT  = 14'h0200,
    S_TSQ    = 14'h0400,
    S_TDEC   = 14'h0800,
    S_RRD    = 14'h1000,
    S_RWAIT  = 14'h2000
  } state_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CARVE  = 2'd1,
    PH_DONE   = 2'd2,
    PH_TARGET = 2'd3
  } phase_e;

  function automatic logic [17:0] nbr(input logic [7:0] x, input logic [7:0] y,
                                      input logic [1:0] dir, input logic far);
    logic [8:0] s;
    logic [8:0] nx;
    logic [8:0] ny;
    s  = far ? 9'd2 : 9'd1;
    nx = {1'b0, x};
    ny = {1'b0, y};
    unique case (dir)
      DIR_SOUTH: ny = ny + s;
      DIR_WEST:  nx = nx - s;
      DIR_NORTH: ny = ny - s;
      default:   nx = nx + s;
    endcase
    return {ny, nx};
  endfunction

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [2:0]    cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          init_pend_q, init_pend_d;
  logic [7:0]    cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [7:0]    org_x_q, org_x_d, org_y_q, org_y_d;
  logic [CW-1:0] scount_q, scount_d;
  logic          pend_q, pend_d;
  logic [7:0]    px_q, px_d, py_q, py_d;
  logic [1:0]    pick_q, pick_d;
  logic [3:0]    free_q, free_d;
  logic [1:0]    pdir_q, pdir_d;
  logic          pinb_q, pinb_d;
  logic          floor_q, floor_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic          done_q, done_d;
  logic [2:0]    status_q, status_d;
  logic [7:0]    cellx_q, cellx_d, celly_q, celly_d;
  logic [7:0]    wallx_q, wallx_d, wally_q, wally_d;
  logic [1:0]    kind_q, kind_d;

  logic [MUL_W-1:0] mul_a, mul_b;
  logic [C_W-1:0]   mul_c;
  logic [ACC_W-1:0] mul_res;
  logic [AW-1:0]    grid_addr;
  logic             vis_we, vis_wd, vis_rd;
  logic             kind_we;
  logic [1:0]       kind_wd, kind_rd;
  logic             stk_we;
  logic [SW-1:0]    stk_addr;
  logic [15:0]      stk_wd, stk_rd;
  logic [CW-1:0]    scount_m1;
  logic [17:0]      far_rd, near_cv, far_pk, near_pk;
  logic             far_inb, req_inb, lat_inb;
  logic [7:0]       clamp_x, clamp_y, dx, dy;

  assign busy    = (state_q != S_IDLE);
  assign done_o  = done_q;
  assign status_o    = status_q;
  assign cell_x_o    = cellx_q;
  assign cell_y_o    = celly_q;
  assign wall_x_o    = wallx_q;
  assign wall_y_o    = wally_q;
  assign cell_kind_o = kind_q;

  assign far_rd  = nbr(cur_x_q, cur_y_q, cnt_q[1:0], 1'b1);
  assign near_cv = nbr(cur_x_q, cur_y_q, cnt_q[1:0], 1'b0);
  assign far_pk  = nbr(cur_x_q, cur_y_q, pick_q, 1'b1);
  assign near_pk = nbr(cur_x_q, cur_y_q, pick_q, 1'b0);
  assign far_inb = (far_rd[8:0] >= 9'd1) && (far_rd[8:0] <= X_HI) &&
                   (far_rd[17:9] >= 9'd1) && (far_rd[17:9] <= Y_HI);
  assign req_inb = ({1'b0, pos_x_i} < X_LIM) && ({1'b0, pos_y_i} < Y_LIM);
  assign lat_inb = ({1'b0, px_q} < X_LIM) && ({1'b0, py_q} < Y_LIM);

  assign clamp_x = (pos_x_i < 8'd1) ? 8'd1 :
                   ({1'b0, pos_x_i} > X_HI) ? X_HI[7:0] : pos_x_i;
  assign clamp_y = (pos_y_i < 8'd1) ? 8'd1 :
                   ({1'b0, pos_y_i} > Y_HI) ? Y_HI[7:0] : pos_y_i;
  assign dx = (px_q > org_x_q) ? (px_q - org_x_q) : (org_x_q - px_q);
  assign dy = (py_q > org_y_q) ? (py_q - org_y_q) : (org_y_q - py_q);
  assign scount_m1 = scount_q - CW'(1);

  assign grid_addr = (state_q == S_CLEAR) ? clr_q : mul_res[AW-1:0];

  mbg_muladd u_muladd (
    .a_i   (mul_a),
    .b_i   (mul_b),
    .c_i   (mul_c),
    .res_o (mul_res)
  );

  mbg_ram #(.DEPTH(CELLS), .WIDTH(1)) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .addr_i  (grid_addr),
    .wdata_i (vis_wd),
    .rdata_o (vis_rd)
  );

  mbg_ram #(.DEPTH(CELLS), .WIDTH(2)) u_kind (
    .clk_i   (clk_i),
    .we_i    (kind_we),
    .addr_i  (grid_addr),
    .wdata_i (kind_wd),
    .rdata_o (kind_rd)
  );

  mbg_ram #(.DEPTH(STACK_DEPTH), .WIDTH(16)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wd),
    .rdata_o (stk_rd)
  );

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    init_pend_d = init_pend_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    org_x_d     = org_x_q;
    org_y_d     = org_y_q;
    scount_d    = scount_q;
    pend_d      = 1'b0;
    px_d        = px_q;
    py_d        = py_q;
    pick_d      = pick_q;
    free_d      = free_q;
    pdir_d      = pdir_q;
    pinb_d      = pinb_q;
    floor_d     = floor_q;
    acc_d       = acc_q;
    done_d      = 1'b0;
    status_d    = status_q;
    cellx_d     = cellx_q;
    celly_d     = celly_q;
    wallx_d     = '0;
    wally_d     = '0;
    kind_d      = KIND_WALL;
    mul_a       = cur_y_q;
    mul_b       = W_MUL;
    mul_c       = C_W'(cur_x_q);
    vis_we      = 1'b0;
    vis_wd      = 1'b0;
    kind_we     = 1'b0;
    kind_wd     = KIND_WALL;
    stk_we      = 1'b0;
    stk_wd      = {cur_y_q, cur_x_q};
    stk_addr    = scount_q[SW-1:0];

    if (pend_q) begin
      free_d[pdir_q] = pinb_q & ~vis_rd;
    end

    unique case (state_q)
      S_CLEAR: begin
        vis_we  = 1'b1;
        kind_we = 1'b1;
        clr_d   = clr_q + AW'(1);
        if (clr_q == CLR_LAST) begin
          clr_d   = '0;
          state_d = init_pend_q ? S_INIT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          px_d   = pos_x_i;
          py_d   = pos_y_i;
          pick_d = pick_i;
          unique case (op_i)
            OP_START: begin
              cur_x_d     = clamp_x;
              cur_y_d     = clamp_y;
              org_x_d     = clamp_x;
              org_y_d     = clamp_y;
              scount_d    = '0;
              phase_d     = PH_CARVE;
              init_pend_d = 1'b1;
              clr_d       = '0;
              state_d     = S_CLEAR;
            end
            OP_STEP: begin
              if (phase_q != PH_CARVE) begin
                done_d   = 1'b1;
                status_d = ST_FINISHED;
                cellx_d  = cur_x_q;
                celly_d  = cur_y_q;
              end else begin
                cnt_d   = '0;
                state_d = S_READ;
              end
            end
            OP_TARGET: begin
              if ((phase_q == PH_DONE) && req_inb) begin
                state_d = S_TRD;
              end else begin
                done_d   = 1'b1;
                status_d = ST_REJECTED;
                cellx_d  = pos_x_i;
                celly_d  = pos_y_i;
              end
            end
            default: begin
              state_d = S_RRD;
            end
          endcase
        end
      end
      S_INIT: begin
        vis_we      = 1'b1;
        vis_wd      = 1'b1;
        kind_we     = 1'b1;
        kind_wd     = KIND_FLOOR;
        init_pend_d = 1'b0;
        done_d      = 1'b1;
        status_d    = ST_STARTED;
        cellx_d     = cur_x_q;
        celly_d     = cur_y_q;
        state_d     = S_IDLE;
      end
      S_READ: begin
        mul_a  = far_rd[16:9];
        mul_c  = C_W'(far_rd[7:0]);
        pend_d = 1'b1;
        pdir_d = cnt_q[1:0];
        pinb_d = far_inb;
        if (cnt_q == 3'd3) begin
          cnt_d   = '0;
          state_d = S_WAIT;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_WAIT: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (free_q == 4'b0000) begin
          if (scount_q != '0) begin
            scount_d = scount_m1;
            stk_addr = scount_m1[SW-1:0];
            state_d  = S_POPW;
          end else begin
            mul_a    = org_y_q;
            mul_c    = C_W'(org_x_q);
            kind_we  = 1'b1;
            kind_wd  = KIND_START;
            phase_d  = PH_DONE;
            done_d   = 1'b1;
            status_d = ST_FINISHED;
            cellx_d  = cur_x_q;
            celly_d  = cur_y_q;
            state_d  = S_IDLE;
          end
        end else if (!free_q[pick_q]) begin
          done_d   = 1'b1;
          status_d = ST_RETRY;
          cellx_d  = cur_x_q;
          celly_d  = cur_y_q;
          state_d  = S_IDLE;
        end else begin
          cnt_d   = '0;
          state_d = S_CARVE;
        end
      end
      S_CARVE: begin
        vis_we = 1'b1;
        vis_wd = 1'b1;
        if (cnt_q == 3'd4) begin
          mul_a    = far_pk[16:9];
          mul_c    = C_W'(far_pk[7:0]);
          kind_we  = 1'b1;
          kind_wd  = KIND_FLOOR;
          cur_x_d  = far_pk[7:0];
          cur_y_d  = far_pk[16:9];
          done_d   = 1'b1;
          status_d = ST_CARVED;
          cellx_d  = far_pk[7:0];
          celly_d  = far_pk[16:9];
          wallx_d  = near_pk[7:0];
          wally_d  = near_pk[16:9];
          cnt_d    = '0;
          state_d  = S_IDLE;
        end else begin
          mul_a   = near_cv[16:9];
          mul_c   = C_W'(near_cv[7:0]);
          kind_we = (cnt_q[1:0] == pick_q);
          kind_wd = KIND_FLOOR;
          if ((cnt_q == 3'd0) && (scount_q < STK_FULL)) begin
            stk_we   = 1'b1;
            scount_d = scount_q + CW'(1);
          end
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_POPW: begin
        cur_x_d  = stk_rd[7:0];
        cur_y_d  = stk_rd[15:8];
        done_d   = 1'b1;
        status_d = ST_BACKTRACKED;
        cellx_d  = stk_rd[7:0];
        celly_d  = stk_rd[15:8];
        state_d  = S_IDLE;
      end
      S_TRD: begin
        mul_a   = py_q;
        mul_c   = C_W'(px_q);
        state_d = S_TWAIT;
      end
      S_TWAIT: begin
        floor_d = (kind_rd == KIND_FLOOR);
        mul_a   = dx;
        mul_b   = dx;
        mul_c   = '0;
        acc_d   = mul_res;
        state_d = S_TSQ;
      end
      S_TSQ: begin
        mul_a   = dy;
        mul_b   = dy;
        mul_c   = acc_q[C_W-1:0];
        acc_d   = mul_res;
        state_d = S_TDEC;
      end
      S_TDEC: begin
        mul_a   = py_q;
        mul_c   = C_W'(px_q);
        done_d  = 1'b1;
        cellx_d = px_q;
        celly_d = py_q;
        state_d = S_IDLE;
        if (floor_q && ({acc_q, 2'b00} >= SUM_WH)) begin
          kind_we  = 1'b1;
          kind_wd  = KIND_TARGET;
          phase_d  = PH_TARGET;
          status_d = ST_PLACED;
        end else begin
          status_d = ST_REJECTED;
        end
      end
      S_RRD: begin
        mul_a   = py_q;
        mul_c   = C_W'(px_q);
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        done_d   = 1'b1;
        status_d = ST_CELL_READ;
        cellx_d  = px_q;
        celly_d  = py_q;
        kind_d   = lat_inb ? kind_rd : KIND_WALL;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      clr_q       <= '0;
      init_pend_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      scount_q    <= '0;
      pend_q      <= 1'b0;
      done_q      <= 1'b0;
      status_q    <= '0;
      cellx_q     <= '0;
      celly_q     <= '0;
      wallx_q     <= '0;
      wally_q     <= '0;
      kind_q      <= '0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      clr_q       <= clr_d;
      init_pend_q <= init_pend_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      org_x_q     <= org_x_d;
      org_y_q     <= org_y_d;
      scount_q    <= scount_d;
      pend_q      <= pend_d;
      done_q      <= done_d;
      status_q    <= status_d;
      cellx_q     <= cellx_d;
      celly_q     <= celly_d;
      wallx_q     <= wallx_d;
      wally_q     <= wally_d;
      kind_q      <= kind_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q    <= px_d;
    py_q    <= py_d;
    pick_q  <= pick_d;
    free_q  <= free_d;
    pdir_q  <= pdir_d;
    pinb_q  <= pinb_d;
    floor_q <= floor_d;
    acc_q   <= acc_d;
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the maze carver: directed items, then random mazes.
module tb;
  import mbg_pkg::*;

  localparam int MAZE_W        = 31;
  localparam int MAZE_H        = 31;
  localparam int PATH_DEPTH    = 256;
  localparam int CELLS         = MAZE_W * MAZE_H;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum logic [1:0] {
    MAZE_IDLE,
    MAZE_CARVING,
    MAZE_DONE,
    MAZE_PLACED
  } maze_phase_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] cell_x;
    logic [7:0] cell_y;
    logic [7:0] wall_x;
    logic [7:0] wall_y;
    logic [1:0] kind;
  } maze_result_t;

  class carve_scoreboard;
    logic [1:0]   kind_map [CELLS];
    bit           seen [CELLS];
    logic [15:0]  trail [PATH_DEPTH];
    int           depth;
    logic [7:0]   cur_x, cur_y, org_x, org_y;
    maze_phase_e  phase;
    maze_result_t expected_results [$];
    int           errors;

    function new();
      clear_grid();
      foreach (trail[i]) trail[i] = '0;
      depth  = 0;
      cur_x  = '0;
      cur_y  = '0;
      org_x  = '0;
      org_y  = '0;
      phase  = MAZE_IDLE;
      errors = 0;
    endfunction

    function void clear_grid();
      foreach (kind_map[i]) kind_map[i] = KIND_WALL;
      foreach (seen[i]) seen[i] = 1'b0;
    endfunction

    function int cell_index(logic [7:0] x, logic [7:0] y);
      return int'(y) * MAZE_W + int'(x);
    endfunction

    function int step_dx(logic [1:0] d);
      case (d)
        DIR_WEST: return -2;
        DIR_EAST: return 2;
        default:  return 0;
      endcase
    endfunction

    function int step_dy(logic [1:0] d);
      case (d)
        DIR_SOUTH: return 2;
        DIR_NORTH: return -2;
        default:   return 0;
      endcase
    endfunction

    // Bit d is set when the cell two away in direction d is inside and unvisited.
    function logic [3:0] free_dirs();
      logic [3:0] open;
      int nx, ny, d;
      for (d = 0; d < 4; d++) begin
        nx = int'(cur_x) + step_dx(2'(d));
        ny = int'(cur_y) + step_dy(2'(d));
        open[d] = nx >= 1 && nx <= MAZE_W - 2 && ny >= 1 && ny <= MAZE_H - 2
                  && !seen[ny * MAZE_W + nx];
      end
      return open;
    endfunction

    function void note_command(logic [1:0] op, logic [7:0] px, logic [7:0] py,
                               logic [1:0] pick);
      maze_result_t want;
      logic [3:0]   open;
      logic [15:0]  entry;
      int           dx, dy;
      want = '0;
      case (op)
        OP_START: begin
          if (px == 8'd0) px = 8'd1;
          if (px > 8'(MAZE_W - 2)) px = 8'(MAZE_W - 2);
          if (py == 8'd0) py = 8'd1;
          if (py > 8'(MAZE_H - 2)) py = 8'(MAZE_H - 2);
          clear_grid();
          depth = 0;
          org_x = px;
          org_y = py;
          cur_x = px;
          cur_y = py;
          kind_map[cell_index(px, py)] = KIND_FLOOR;
          seen[cell_index(px, py)] = 1'b1;
          phase = MAZE_CARVING;
          want.status = ST_STARTED;
          want.cell_x = px;
          want.cell_y = py;
        end
        OP_STEP: begin
          open = free_dirs();
          if (phase != MAZE_CARVING) begin
            want.status = ST_FINISHED;
          end else if (open == 4'b0000) begin
            if (depth > 0) begin
              depth--;
              entry = trail[depth % PATH_DEPTH];
              cur_x = entry[7:0];
              cur_y = entry[15:8];
              want.status = ST_BACKTRACKED;
            end else begin
              kind_map[cell_index(org_x, org_y)] = KIND_START;
              phase = MAZE_DONE;
              want.status = ST_FINISHED;
            end
          end else if (!open[pick]) begin
            want.status = ST_RETRY;
          end else begin
            seen[cell_index(cur_x + 8'd1, cur_y)] = 1'b1;
            seen[cell_index(cur_x - 8'd1, cur_y)] = 1'b1;
            seen[cell_index(cur_x, cur_y + 8'd1)] = 1'b1;
            seen[cell_index(cur_x, cur_y - 8'd1)] = 1'b1;
            if (depth < PATH_DEPTH) begin
              trail[depth] = {cur_y, cur_x};
              depth++;
            end
            want.wall_x = 8'(int'(cur_x) + step_dx(pick) / 2);
            want.wall_y = 8'(int'(cur_y) + step_dy(pick) / 2);
            kind_map[cell_index(want.wall_x, want.wall_y)] = KIND_FLOOR;
            cur_x = 8'(int'(cur_x) + step_dx(pick));
            cur_y = 8'(int'(cur_y) + step_dy(pick));
            seen[cell_index(cur_x, cur_y)] = 1'b1;
            kind_map[cell_index(cur_x, cur_y)] = KIND_FLOOR;
            want.status = ST_CARVED;
          end
          want.cell_x = cur_x;
          want.cell_y = cur_y;
        end
        OP_TARGET: begin
          want.status = ST_REJECTED;
          want.cell_x = px;
          want.cell_y = py;
          if (phase == MAZE_DONE && px < MAZE_W && py < MAZE_H
              && kind_map[cell_index(px, py)] == KIND_FLOOR) begin
            dx = int'(px) - int'(org_x);
            dy = int'(py) - int'(org_y);
            if (4 * (dx * dx + dy * dy) >= MAZE_W + MAZE_H) begin
              kind_map[cell_index(px, py)] = KIND_TARGET;
              phase = MAZE_PLACED;
              want.status = ST_PLACED;
            end
          end
        end
        default: begin
          want.status = ST_CELL_READ;
          want.cell_x = px;
          want.cell_y = py;
          if (px < MAZE_W && py < MAZE_H) want.kind = kind_map[cell_index(px, py)];
        end
      endcase
      expected_results = {expected_results, want};
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(maze_result_t got);
      maze_result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result expected none got status %0d", $time, got.status);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("cell_x", want.cell_x, got.cell_x);
      compare_field("cell_y", want.cell_y, got.cell_y);
      compare_field("wall_x", want.wall_x, got.wall_x);
      compare_field("wall_y", want.wall_y, got.wall_y);
      compare_field("cell_kind", want.kind, got.kind);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni  = 1'b0;
  logic       start   = 1'b0;
  logic [1:0] op_i    = OP_READ;
  logic [7:0] pos_x_i = '0;
  logic [7:0] pos_y_i = '0;
  logic [1:0] pick_i  = DIR_SOUTH;
  logic       busy;
  logic       done_o;
  logic [2:0] status_o;
  logic [7:0] cell_x_o, cell_y_o, wall_x_o, wall_y_o;
  logic [1:0] cell_kind_o;

  carve_scoreboard sb;
  int idle_pct = 0;
  int cycles   = 0;

  maze_backtracker_generator_top #(
    .MAZE_WIDTH (MAZE_W),
    .MAZE_HEIGHT(MAZE_H),
    .STACK_DEPTH(PATH_DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .op_i       (op_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pick_i     (pick_i),
    .done_o     (done_o),
    .status_o   (status_o),
    .cell_x_o   (cell_x_o),
    .cell_y_o   (cell_y_o),
    .wall_x_o   (wall_x_o),
    .wall_y_o   (wall_y_o),
    .cell_kind_o(cell_kind_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(maze_result_t'({status_o, cell_x_o, cell_y_o, wall_x_o, wall_y_o,
                                      cell_kind_o}));
    end
  end

  function automatic logic [7:0] any_coord(int grid_size);
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, grid_size - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [1:0] any_dir();
    return 2'($urandom_range(0, 3));
  endfunction

  // Presents one item and returns at the edge that accepts it; start stays high.
  task automatic send_cmd(input logic [1:0] op, input logic [7:0] x, input logic [7:0] y,
                          input logic [1:0] pick);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start   <= 1'b1;
    op_i    <= op;
    pos_x_i <= x;
    pos_y_i <= y;
    pick_i  <= pick;
    do @(posedge clk_i); while (busy);
    sb.note_command(op, x, y, pick);
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_results.size() != 0) @(posedge clk_i);
  endtask

  // One maze: a start, steps mostly towards free cells, then targets and reads.
  task automatic maze_episode(input int step_limit);
    int         near_dx [6] = '{2, 2, -2, 0, 0, 4};
    int         near_dy [6] = '{0, 2, -2, 4, -4, 0};
    logic [3:0] open;
    logic [1:0] dir;
    logic [7:0] tx, ty;
    int         steps, tries, sent;
    if ($urandom_range(0, 1) == 0)
      send_cmd(OP_START, any_coord(256), any_coord(256), any_dir());
    else
      send_cmd(OP_START, 8'($urandom_range(1, MAZE_W - 2)),
               8'($urandom_range(1, MAZE_H - 2)), any_dir());
    steps = 0;
    while (sb.phase == MAZE_CARVING && steps < step_limit) begin
      if ($urandom_range(0, 99) < 3) begin
        send_cmd($urandom_range(0, 1) ? OP_READ : OP_TARGET, any_coord(MAZE_W),
                 any_coord(MAZE_H), any_dir());
      end
      open = sb.free_dirs();
      dir  = any_dir();
      if (open != 4'b0000 && $urandom_range(0, 99) < 75) begin
        while (!open[dir]) dir = dir + 2'd1;
      end
      send_cmd(OP_STEP, any_coord(256), any_coord(256), dir);
      steps++;
    end
    repeat (2) send_cmd(OP_STEP, any_coord(256), any_coord(256), any_dir());
    // Candidates just inside and just outside the minimum distance from the start cell.
    foreach (near_dx[i]) begin
      send_cmd(OP_TARGET, 8'(int'(sb.org_x) + near_dx[i]), 8'(int'(sb.org_y) + near_dy[i]),
               any_dir());
    end
    tries = 0;
    sent  = 0;
    while (sb.phase != MAZE_PLACED && tries < 400 && sent < 8) begin
      tx = 8'($urandom_range(0, MAZE_W - 1));
      ty = 8'($urandom_range(0, MAZE_H - 1));
      if (sb.kind_map[sb.cell_index(tx, ty)] == KIND_FLOOR || tries % 50 == 49) begin
        send_cmd(OP_TARGET, tx, ty, any_dir());
        sent++;
      end
      tries++;
    end
    send_cmd(OP_TARGET, any_coord(256), any_coord(256), any_dir());
    send_cmd(OP_READ, sb.org_x, sb.org_y, any_dir());
    repeat (8) send_cmd(OP_READ, any_coord(MAZE_W), any_coord(MAZE_H), any_dir());
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(OP_READ, 8'd0, 8'd0, DIR_SOUTH);
    send_cmd(OP_READ, 8'd255, 8'd255, DIR_EAST);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_SOUTH);
    send_cmd(OP_TARGET, 8'd5, 8'd5, DIR_WEST);
    send_cmd(OP_START, 8'd0, 8'd0, DIR_NORTH);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_WEST);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_NORTH);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_SOUTH);
    send_cmd(OP_STEP, 8'd255, 8'd255, DIR_EAST);
    send_cmd(OP_TARGET, 8'd1, 8'd1, DIR_SOUTH);
    send_cmd(OP_READ, 8'd1, 8'd1, DIR_SOUTH);
    send_cmd(OP_READ, 8'd1, 8'd2, DIR_SOUTH);
    send_cmd(OP_READ, 8'd30, 8'd30, DIR_SOUTH);
    send_cmd(OP_READ, 8'd31, 8'd0, DIR_SOUTH);
    send_cmd(OP_READ, 8'd0, 8'd31, DIR_SOUTH);
    send_cmd(OP_START, 8'd255, 8'd255, DIR_EAST);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_SOUTH);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_EAST);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_NORTH);
    send_cmd(OP_STEP, 8'd0, 8'd0, DIR_WEST);
    send_cmd(OP_START, 8'd0, 8'd255, DIR_SOUTH);
    send_cmd(OP_START, 8'd255, 8'd0, DIR_SOUTH);
    send_cmd(OP_START, 8'd15, 8'd15, DIR_EAST);

    wait_for_results();
    idle_pct = 0;
    maze_episode(5000);
    wait_for_results();
    idle_pct = 80;
    maze_episode($urandom_range(40, 200));
    wait_for_results();
    idle_pct = 20;
    maze_episode(5000);
    wait_for_results();
    idle_pct = 0;
    maze_episode($urandom_range(40, 200));

    start <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
